// ===== hw/rtl/indexed_max_heap_update_core_defines.svh =====
// Assertion macros shared by the heap RTL.
`ifndef INDEXED_MAX_HEAP_UPDATE_CORE_DEFINES_SVH
`define INDEXED_MAX_HEAP_UPDATE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("imh assertion failed");
`define IMH_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("imh forbidden condition seen");
`else
`define IMH_ASSERT(lbl, clk, rst_n, prop)
`define IMH_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/imh_pkg.sv =====
// Package: sizes, codes, entry type and rank compare of the indexed max-heap.
package imh_pkg;
  localparam int unsigned HEAP_CAPACITY = 64;
  localparam int unsigned KEY_COUNT     = 256;
  localparam int unsigned PRIO_W        = 32;
  localparam int unsigned KEY_W         = 8;
  localparam int unsigned SLOT_W        = $clog2(HEAP_CAPACITY);
  localparam int unsigned CNT_W         = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned ENTRY_W       = PRIO_W + KEY_W;
  localparam int unsigned DATA_IN_W     = 48;
  localparam int unsigned DATA_OUT_W    = 56;

  typedef enum logic [1:0] {
    OP_PEEK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_ERASE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [KEY_W-1:0]         key;
  } entry_t;

  // a ranks above b: higher priority, ties go to the larger key
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = ($signed(a.prio) > $signed(b.prio));
    end else begin
      res = (a.key > b.key);
    end
    return res;
  endfunction
endpackage

// ===== hw/rtl/imh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module imh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/indexed_max_heap_update_core.sv =====
// Top level: indexed binary max-heap with key-to-slot map, sequenced over shared RAM ports.
//  channel  | dir | tdata fields (low bit first)
//  s_axis   | in  | operation[1:0] item_key[9:2] item_priority[41:10]
//  m_axis   | out | status, is_empty, top_key, top_priority, entry_count, key_was_present
// A transaction's length grows with each level climbed or descended, set by the single read
// port of the slot RAM and the one rank comparator.
// s_axis_tready_o is high only in idle; a finished result waits in the output register.
// Reset clears the key valid bits and the count at once; no clearing pass.
`include "indexed_max_heap_update_core_defines.svh"
module indexed_max_heap_update_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // operation[1:0], item_key[9:2], item_priority[41:10], zero fill
  input  logic [imh_pkg::DATA_IN_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // status[1:0], is_empty[2], top_key[10:3], top_priority[42:11],
  // entry_count[49:43], key_was_present[50], zero fill
  output logic [imh_pkg::DATA_OUT_W-1:0]  m_axis_tdata_o
);
  import imh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_RM_RD0, S_RM_KEY, S_RM_CLR, S_RM_LAST,
    S_UP_RD, S_UP_CMP, S_DN_CHK, S_DN_RL, S_DN_RR, S_DN_PICK, S_FIN, S_TOP
  } state_e;

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [KEY_W-1:0]       key_q, key_d, rmkey_q, rmkey_d;
  logic [PRIO_W-1:0]      prio_q, prio_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SLOT_W-1:0]      idx_q, idx_d, bidx_q, bidx_d;
  entry_t                 hold_q, hold_d, best_q, best_d;
  logic                   present_q, present_d;
  status_e                status_q, status_d;
  logic [KEY_COUNT-1:0]   kvalid_q, kvalid_d;

  logic                   mvalid_q, mvalid_d;
  status_e                out_status_q, out_status_d;
  logic                   out_empty_q, out_empty_d;
  logic [KEY_W-1:0]       out_key_q, out_key_d;
  logic [PRIO_W-1:0]      out_prio_q, out_prio_d;
  logic [CNT_W-1:0]       out_count_q, out_count_d;
  logic                   out_kwp_q, out_kwp_d;

  logic                   slot_we;
  logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
  entry_t                 slot_wdata;
  logic [ENTRY_W-1:0]     slot_rdata;
  entry_t                 slot_rd;
  logic                   pos_we;
  logic [KEY_W-1:0]       pos_waddr;
  logic [CNT_W-1:0]       pos_wdata, pos_rd;

  entry_t                 cmp_a, cmp_b;
  logic                   cmp_above;
  logic [CNT_W-1:0]       left_idx, last_idx;
  logic [CNT_W:0]         right_idx;
  logic [SLOT_W-1:0]      parent_idx;
  logic                   present_now;

  imh_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  imh_ram #(.WIDTH(CNT_W), .DEPTH(KEY_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (key_q),
    .rdata_o (pos_rd)
  );

  assign slot_rd    = entry_t'(slot_rdata);
  assign left_idx   = {idx_q, 1'b1};
  assign right_idx  = {1'b0, left_idx} + 1'b1;
  assign last_idx   = cnt_q - 1'b1;
  assign parent_idx = SLOT_W'((idx_q - 1'b1) >> 1);
  assign cmp_above  = ranks_above(cmp_a, cmp_b);
  assign present_now = kvalid_q[key_q] && (pos_rd != '0) && (pos_rd <= cnt_q);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {5'b0, out_kwp_q, out_count_q, out_prio_q, out_key_q,
                            out_empty_q, out_status_q};

  // shared comparator operands
  always_comb begin
    unique case (state_q)
      S_DN_RR: begin
        cmp_a = slot_rd;
        cmp_b = best_q;
      end
      S_DN_PICK: begin
        cmp_a = best_q;
        cmp_b = hold_q;
      end
      default: begin
        cmp_a = hold_q;
        cmp_b = slot_rd;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    prio_d       = prio_q;
    rmkey_d      = rmkey_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    bidx_d       = bidx_q;
    hold_d       = hold_q;
    best_d       = best_q;
    present_d    = present_q;
    status_d     = status_q;
    kvalid_d     = kvalid_q;
    mvalid_d     = mvalid_q;
    out_status_d = out_status_q;
    out_empty_d  = out_empty_q;
    out_key_d    = out_key_q;
    out_prio_d   = out_prio_q;
    out_count_d  = out_count_q;
    out_kwp_d    = out_kwp_q;
    slot_we      = 1'b0;
    slot_waddr   = idx_q;
    slot_wdata   = hold_q;
    slot_raddr   = '0;
    pos_we       = 1'b0;
    pos_waddr    = hold_q.key;
    pos_wdata    = {1'b0, idx_q} + 1'b1;

    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = op_e'(s_axis_tdata_i[1:0]);
          key_d    = s_axis_tdata_i[9:2];
          prio_d   = s_axis_tdata_i[41:10];
          status_d = ST_OK;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: state_d = S_DECIDE;
      S_DECIDE: begin
        present_d = present_now;
        unique case (op_q)
          OP_PEEK: begin
            if (cnt_q == '0) status_d = ST_EMPTY;
            state_d = S_FIN;
          end
          OP_INSERT: begin
            hold_d = '{prio: prio_q, key: key_q};
            if (present_now) begin
              idx_d   = SLOT_W'(pos_rd - 1'b1);
              state_d = S_UP_RD;
            end else if (cnt_q >= CNT_W'(HEAP_CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              idx_d   = cnt_q[SLOT_W-1:0];
              cnt_d   = cnt_q + 1'b1;
              state_d = S_UP_RD;
            end
          end
          OP_POP: begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              idx_d   = '0;
              state_d = S_RM_RD0;
            end
          end
          default: begin
            if (!present_now) begin
              status_d = ST_ABSENT;
              state_d  = S_FIN;
            end else begin
              idx_d   = SLOT_W'(pos_rd - 1'b1);
              rmkey_d = key_q;
              state_d = S_RM_CLR;
            end
          end
        endcase
      end
      S_RM_RD0: state_d = S_RM_KEY;
      S_RM_KEY: begin
        rmkey_d = slot_rd.key;
        state_d = S_RM_CLR;
      end
      S_RM_CLR: begin
        kvalid_d[rmkey_q] = 1'b0;
        cnt_d = last_idx;
        slot_raddr = last_idx[SLOT_W-1:0];
        if ({1'b0, idx_q} == last_idx) begin
          state_d = S_FIN;
        end else begin
          state_d = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        hold_d  = slot_rd;
        state_d = S_UP_RD;
      end
      S_UP_RD: begin
        slot_raddr = parent_idx;
        state_d = (idx_q == '0) ? S_DN_CHK : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (cmp_above) begin
          // parent moves down into the hole
          slot_we    = 1'b1;
          slot_wdata = slot_rd;
          pos_we     = 1'b1;
          pos_waddr  = slot_rd.key;
          idx_d      = parent_idx;
          state_d    = S_UP_RD;
        end else begin
          state_d = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        slot_raddr = left_idx[SLOT_W-1:0];
        if (left_idx >= cnt_q) begin
          slot_we  = 1'b1;
          pos_we   = 1'b1;
          kvalid_d[hold_q.key] = 1'b1;
          state_d  = S_FIN;
        end else begin
          state_d = S_DN_RL;
        end
      end
      S_DN_RL: begin
        slot_raddr = right_idx[SLOT_W-1:0];
        best_d  = slot_rd;
        bidx_d  = left_idx[SLOT_W-1:0];
        state_d = S_DN_RR;
      end
      S_DN_RR: begin
        if ((right_idx < {1'b0, cnt_q}) && cmp_above) begin
          best_d = slot_rd;
          bidx_d = right_idx[SLOT_W-1:0];
        end
        state_d = S_DN_PICK;
      end
      S_DN_PICK: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (cmp_above) begin
          // better child moves up into the hole
          slot_wdata = best_q;
          pos_waddr  = best_q.key;
          idx_d      = bidx_q;
          state_d    = S_DN_CHK;
        end else begin
          kvalid_d[hold_q.key] = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: state_d = S_TOP;
      S_TOP: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d     = 1'b1;
          out_status_d = status_q;
          out_empty_d  = (cnt_q == '0);
          out_key_d    = (cnt_q == '0) ? '0 : slot_rd.key;
          out_prio_d   = (cnt_q == '0) ? '0 : slot_rd.prio;
          out_count_d  = cnt_q;
          out_kwp_d    = present_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_PEEK;
      key_q        <= '0;
      prio_q       <= '0;
      rmkey_q      <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      bidx_q       <= '0;
      hold_q       <= '0;
      best_q       <= '0;
      present_q    <= 1'b0;
      status_q     <= ST_OK;
      kvalid_q     <= '0;
      mvalid_q     <= 1'b0;
      out_status_q <= ST_OK;
      out_empty_q  <= 1'b1;
      out_key_q    <= '0;
      out_prio_q   <= '0;
      out_count_q  <= '0;
      out_kwp_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_q        <= key_d;
      prio_q       <= prio_d;
      rmkey_q      <= rmkey_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      bidx_q       <= bidx_d;
      hold_q       <= hold_d;
      best_q       <= best_d;
      present_q    <= present_d;
      status_q     <= status_d;
      kvalid_q     <= kvalid_d;
      mvalid_q     <= mvalid_d;
      out_status_q <= out_status_d;
      out_empty_q  <= out_empty_d;
      out_key_q    <= out_key_d;
      out_prio_q   <= out_prio_d;
      out_count_q  <= out_count_d;
      out_kwp_q    <= out_kwp_d;
    end
  end

  `IMH_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CNT_W'(HEAP_CAPACITY))
  `IMH_ASSERT(a_busy_after_accept, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
  `IMH_ASSERT(a_full_at_cap, clk_i, rst_ni, (mvalid_q && out_status_q == ST_FULL) |-> (out_count_q == CNT_W'(HEAP_CAPACITY)))
  `IMH_ASSERT(a_empty_flag, clk_i, rst_ni, mvalid_q |-> (out_empty_q == (out_count_q == '0)))
  `IMH_ASSERT_NEVER(a_no_absent_present, clk_i, rst_ni, mvalid_q && out_status_q == ST_ABSENT && out_kwp_q)
endmodule

// ===== tb/testbench.sv =====
// Testbench for the indexed max-heap core: directed and random heap operations checked by a scoreboard.
`timescale 1ns / 1ps
module testbench;
  import imh_pkg::*;

  typedef struct packed {
    status_e          status;
    logic             is_empty;
    logic [7:0]       top_key;
    logic [31:0]      top_prio;
    logic [6:0]       count;
    logic             was_present;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [31:0] prio_q[HEAP_CAPACITY];
    logic [7:0]         key_q[HEAP_CAPACITY];
    int                 pos_of[KEY_COUNT];
    int                 fill;
    heap_result_t       pending[$];
    int                 errors;

    function new();
      for (int k = 0; k < KEY_COUNT; k++) pos_of[k] = 0;
      fill = 0;
      errors = 0;
    endfunction

    function bit above(int a, int b);
      if (prio_q[a] != prio_q[b]) return prio_q[a] > prio_q[b];
      return key_q[a] > key_q[b];
    endfunction

    function void swap_slots(int a, int b);
      logic signed [31:0] tp;
      logic [7:0] tk;
      tp = prio_q[a]; tk = key_q[a];
      prio_q[a] = prio_q[b]; key_q[a] = key_q[b];
      prio_q[b] = tp; key_q[b] = tk;
      pos_of[key_q[a]] = a + 1;
      pos_of[key_q[b]] = b + 1;
    endfunction

    function void climb(int i);
      while (i > 0 && above(i, (i - 1) / 2)) begin
        swap_slots(i, (i - 1) / 2);
        i = (i - 1) / 2;
      end
    endfunction

    function void descend(int i);
      int best;
      forever begin
        best = i;
        if (2 * i + 1 < fill && above(2 * i + 1, best)) best = 2 * i + 1;
        if (2 * i + 2 < fill && above(2 * i + 2, best)) best = 2 * i + 2;
        if (best == i) break;
        swap_slots(i, best);
        i = best;
      end
    endfunction

    function void drop_slot(int i);
      pos_of[key_q[i]] = 0;
      if (i != fill - 1) begin
        prio_q[i] = prio_q[fill - 1];
        key_q[i] = key_q[fill - 1];
        pos_of[key_q[i]] = i + 1;
      end
      fill--;
      if (i < fill) begin
        climb(i);
        descend(i);
      end
    endfunction

    function void note_input(op_e op, logic [7:0] key, logic signed [31:0] prio);
      heap_result_t r;
      bit present;
      present = pos_of[key] != 0;
      r.status = ST_OK;
      case (op)
        OP_PEEK: if (fill == 0) r.status = ST_EMPTY;
        OP_INSERT: begin
          if (present) begin
            prio_q[pos_of[key] - 1] = prio;
            climb(pos_of[key] - 1);
            descend(pos_of[key] - 1);
          end else if (fill >= HEAP_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            prio_q[fill] = prio;
            key_q[fill] = key;
            pos_of[key] = fill + 1;
            fill++;
            climb(fill - 1);
          end
        end
        OP_POP: begin
          if (fill == 0) r.status = ST_EMPTY;
          else drop_slot(0);
        end
        default: begin
          if (!present) r.status = ST_ABSENT;
          else drop_slot(pos_of[key] - 1);
        end
      endcase
      r.is_empty = fill == 0;
      r.top_key = fill == 0 ? 8'd0 : key_q[0];
      r.top_prio = fill == 0 ? 32'd0 : prio_q[0];
      r.count = 7'(fill);
      r.was_present = present;
      pending = {pending, r};
    endfunction

    function void check_result(logic [DATA_OUT_W-1:0] d);
      heap_result_t e;
      if (pending.size() == 0) begin
        $error("result with no expectation: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[1:0] !== e.status) begin
        $error("status exp %0d got %0d", e.status, d[1:0]); errors++;
      end
      if (d[2] !== e.is_empty) begin
        $error("is_empty exp %0d got %0d", e.is_empty, d[2]); errors++;
      end
      if (d[10:3] !== e.top_key) begin
        $error("top_key exp %0d got %0d", e.top_key, d[10:3]); errors++;
      end
      if (d[42:11] !== e.top_prio) begin
        $error("top_priority exp %h got %h", e.top_prio, d[42:11]); errors++;
      end
      if (d[49:43] !== e.count) begin
        $error("entry_count exp %0d got %0d", e.count, d[49:43]); errors++;
      end
      if (d[50] !== e.was_present) begin
        $error("key_was_present exp %0d got %0d", e.was_present, d[50]); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o, m_axis_tvalid_o, m_axis_tready_i;
  logic [DATA_IN_W-1:0]  s_axis_tdata_i;
  logic [DATA_OUT_W-1:0] m_axis_tdata_o;

  heap_scoreboard sb;
  bit  no_idle;
  bit  hold_sink;
  bit  stim_done;
  int  quiet_cycles;

  indexed_max_heap_update_core uut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_op(op_e op, logic [7:0] key, logic [31:0] prio);
    while (!no_idle && $urandom_range(99) < 32) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'd0, prio, key, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(op, key, prio);
  endtask

  function automatic logic [31:0] pick_prio();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  // sink side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      m_axis_tready_i <= !hold_sink && (no_idle || $urandom_range(99) >= 32);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int narrow;
    op_e op;
    sb = new();
    rst_ni = 0;
    s_axis_tvalid_i = 0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 0;
    no_idle = 0;
    hold_sink = 0;
    stim_done = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty cases, extremes, ties, update, erase absent
    send_op(OP_PEEK, 8'd0, 32'd0);
    send_op(OP_POP, 8'd0, 32'd0);
    send_op(OP_ERASE, 8'd5, 32'd0);
    send_op(OP_INSERT, 8'd0, 32'h8000_0000);
    send_op(OP_INSERT, 8'd255, 32'h7fff_ffff);
    send_op(OP_INSERT, 8'd10, 32'h7fff_ffff);
    send_op(OP_PEEK, 8'd0, 32'd0);
    send_op(OP_INSERT, 8'd255, 32'hffff_ffff);
    send_op(OP_INSERT, 8'd0, 32'h7fff_fffe);
    send_op(OP_ERASE, 8'd10, 32'd0);
    send_op(OP_ERASE, 8'd10, 32'd0);
    send_op(OP_INSERT, 8'haa, 32'h5555_5555);
    send_op(OP_INSERT, 8'h55, 32'haaaa_aaaa);
    send_op(OP_POP, 8'd0, 32'd0);
    send_op(OP_POP, 8'd0, 32'd0);
    send_op(OP_POP, 8'd0, 32'd0);
    send_op(OP_POP, 8'd0, 32'd0);
    send_op(OP_PEEK, 8'd0, 32'd0);
    // fill to capacity, then a full insert, with the sink held off
    hold_sink <= 1;
    fork
      begin repeat (300) @(posedge clk_i); hold_sink <= 0; end
    join_none
    for (int k = 0; k < HEAP_CAPACITY; k++) send_op(OP_INSERT, k[7:0] + 8'd100, pick_prio());
    send_op(OP_INSERT, 8'd7, 32'd1);
    send_op(OP_INSERT, 8'd100, 32'd3);
    // sender waits for everything to drain
    s_axis_tvalid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);

    for (int n = 0; n < 566; n++) begin
      no_idle = (n >= 200 && n < 300);
      narrow = (n % 200) < 120;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: op = OP_INSERT;
        5, 6: op = OP_POP;
        7, 8: op = OP_ERASE;
        default: op = OP_PEEK;
      endcase
      send_op(op, narrow ? 8'($urandom_range(40)) : 8'($urandom_range(255)), pick_prio());
    end
    s_axis_tvalid_i <= 0;
    no_idle = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/imh_pkg.sv
hw/rtl/imh_ram.sv
hw/rtl/indexed_max_heap_update_core.sv
tb/testbench.sv
